// File: src/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg: shared types and constants of the partition allocator
// Holds the request modes, result codes, controller states and the command
// and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package vpa_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int MEMORY_UNITS_DEF  = 1024;
	localparam int INITIAL_BLOCKS    = 8;

	localparam int MODE_W   = 3;
	localparam int OWNER_W  = 8;
	localparam int REQ_W    = 11;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 5;
	localparam int FRAG_W   = 11;

	typedef enum logic [MODE_W-1:0] {
		MODE_REINIT = 3'd0,
		MODE_FIRST  = 3'd1,
		MODE_BEST   = 3'd2,
		MODE_WORST  = 3'd3,
		MODE_FREE   = 3'd4,
		MODE_FRAG   = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BADSIZE = 2'd1,
		ST_NOFIT   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SEARCH,
		S_TAKE,
		S_SHIFT,
		S_SPLIT,
		S_FREE,
		S_SUM,
		S_DIV,
		S_HOLES,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request
		logic clr_idx;   // scan index to 0
		logic inc_idx;   // scan index + 1
		logic init_step; // write reset entry at scan index
		logic init_end;  // set active count to 8
		logic search;    // evaluate fit candidate
		logic take;      // mark picked entry used
		logic shift_set; // scan index to active count
		logic shift_step;// move entry idx-1 to idx, idx - 1
		logic split;     // write remainder, resize pick
		logic free_step; // free entry at scan index if owner matches
		logic sum_step;  // accumulate used entry
		logic div_start; // start average divide
		logic div_step;  // one quotient bit
		logic hole_step; // accumulate small free entry
		logic set_status;// latch status code
		logic present;   // copy result into output register
		status_t status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic    idx_end;   // scan index reached active count or table end
		logic    req_zero;
		logic    found;
		logic    first_hit; // current entry is free and large enough
		logic    need_split;
		logic    shift_done;
		logic    div_done;
		logic    avg_zero;
		logic    used_none;
		logic    init_done;
	} sts_t;

endpackage

// File: src/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl: request sequencer
// Steps the datapath through one request and presents one result.
// ----------------------------------------------------------------------------
module vpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vpa_pkg::mode_t  mode,
	output logic            out_valid,
	input  logic            out_ready,
	output vpa_pkg::cmd_t   cmd,
	input  vpa_pkg::sts_t   sts
);
	import vpa_pkg::*;

	state_t state_q, state_d;
	mode_t  mode_q;
	logic   ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			mode_q  <= MODE_REINIT;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
			if (in_valid && in_ready) mode_q <= mode;
		end
	end

	assign out_valid = ov_q;
	// next request may enter while the previous result waits
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ov_d    = ov_q && !out_ready;
		cmd     = '0;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.clr_idx = 1'b1;
					case (mode)
						MODE_REINIT: state_d = S_INIT;
						MODE_FIRST, MODE_BEST, MODE_WORST: state_d = S_SEARCH;
						MODE_FREE:   state_d = S_FREE;
						MODE_FRAG:   state_d = S_SUM;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				cmd.inc_idx   = 1'b1;
				if (sts.init_done) begin
					cmd.init_end = 1'b1;
					state_d = S_DONE;
				end
			end
			S_SEARCH: begin
				if (sts.req_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_BADSIZE;
					state_d = S_DONE;
				end else if (sts.idx_end || (mode_q == MODE_FIRST && sts.found)) begin
					if (sts.found) state_d = S_TAKE;
					else begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_NOFIT;
						state_d = S_DONE;
					end
				end else begin
					cmd.search  = 1'b1;
					cmd.inc_idx = 1'b1;
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				if (sts.need_split) begin
					cmd.shift_set = 1'b1;
					state_d = S_SHIFT;
				end else state_d = S_DONE;
			end
			S_SHIFT: begin
				if (sts.shift_done) state_d = S_SPLIT;
				else cmd.shift_step = 1'b1;
			end
			S_SPLIT: begin
				cmd.split = 1'b1;
				state_d = S_DONE;
			end
			S_FREE: begin
				if (sts.idx_end) state_d = S_DONE;
				else begin
					cmd.free_step = 1'b1;
					cmd.inc_idx   = 1'b1;
				end
			end
			S_SUM: begin
				if (sts.idx_end) begin
					if (sts.used_none) state_d = S_DONE;
					else begin
						cmd.div_start = 1'b1;
						state_d = S_DIV;
					end
				end else begin
					cmd.sum_step = 1'b1;
					cmd.inc_idx  = 1'b1;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.clr_idx = 1'b1;
					state_d = sts.avg_zero ? S_DONE : S_HOLES;
				end else cmd.div_step = 1'b1;
			end
			S_HOLES: begin
				if (sts.idx_end) state_d = S_DONE;
				else begin
					cmd.hole_step = 1'b1;
					cmd.inc_idx   = 1'b1;
				end
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.present = 1'b1;
					ov_d    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("ready while busy");
	a_done_raises: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!ov_q || out_ready)) |=> out_valid)
		else $error("result not presented");
	a_split_after_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |-> $past(state_q == S_SHIFT))
		else $error("split without shift");
`endif
endmodule

// File: src/vpa_dp.sv
// ----------------------------------------------------------------------------
// vpa_dp: block table and arithmetic
// Block table in flip-flops indexed by a scan counter, fit search, shift,
// free sweep, used-size sum, serial divider and hole sum.
// ----------------------------------------------------------------------------
module vpa_dp #(
	parameter int TABLE_ENTRIES = vpa_pkg::TABLE_ENTRIES_DEF,
	parameter int MEMORY_UNITS  = vpa_pkg::MEMORY_UNITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vpa_pkg::mode_t             mode,
	input  logic [vpa_pkg::OWNER_W-1:0] owner_id,
	input  logic [vpa_pkg::REQ_W-1:0]  req_units,
	input  vpa_pkg::cmd_t              cmd,
	output vpa_pkg::sts_t              sts,
	output logic [vpa_pkg::STATUS_W-1:0] status,
	output logic [vpa_pkg::INDEX_W-1:0]  slot_index,
	output logic [vpa_pkg::FRAG_W-1:0]   hole_total
);
	import vpa_pkg::*;

	localparam int IW   = $clog2(TABLE_ENTRIES);
	localparam int CW   = $clog2(TABLE_ENTRIES + 1);
	localparam int UW   = $clog2(MEMORY_UNITS + 1);
	localparam int PART = MEMORY_UNITS / INITIAL_BLOCKS;
	localparam int SW   = UW + CW;
	localparam int DW   = $clog2(SW + 1);

	// flip-flop table at scan index, idx-1 for shift, pick/pick+1 for take/split
	logic [UW-1:0]      start_q [TABLE_ENTRIES];
	logic [UW-1:0]      size_q  [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] free_q;
	logic [OWNER_W-1:0] owner_q [TABLE_ENTRIES];

	logic [CW-1:0]      act_q;
	logic [CW-1:0]      idx_q;
	logic [OWNER_W-1:0] own_q;
	logic [UW-1:0]      want_q;
	logic               zero_q;
	logic               found_q;
	logic [IW-1:0]      pick_q;
	logic [UW-1:0]      psize_q;
	logic [UW-1:0]      pstart_q;
	logic [SW-1:0]      sum_q;
	logic [CW-1:0]      used_q;
	logic [SW-1:0]      rem_q;
	logic [SW-1:0]      quo_q;
	logic [DW-1:0]      dcnt_q;
	logic [UW-1:0]      hole_q;
	logic [STATUS_W-1:0] st_q;
	logic [INDEX_W-1:0] bi_q;
	logic               frag_mode_q;
	mode_t              mode_q;
	logic [STATUS_W-1:0] out_st_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic [FRAG_W-1:0]  out_frag_q;

	logic [IW-1:0] ix;
	logic [IW-1:0] ixm1;
	logic          cur_fit;
	logic          better;
	logic [SW-1:0] rem_sh;

	assign ix      = idx_q[IW-1:0];
	assign ixm1    = ix - IW'(1);
	assign cur_fit = free_q[ix] && (size_q[ix] >= want_q);
	assign better  = (mode_q == MODE_BEST)  ? (size_q[ix] < psize_q) :
	                 (mode_q == MODE_WORST) ? (size_q[ix] > psize_q) : 1'b0;
	assign rem_sh  = {rem_q[SW-2:0], quo_q[SW-1]};

	always_comb begin
		sts = '0;
		sts.idx_end    = (idx_q >= act_q) || (idx_q == CW'(TABLE_ENTRIES));
		sts.req_zero   = zero_q;
		sts.found      = found_q;
		sts.first_hit  = cur_fit;
		sts.need_split = (psize_q != want_q) && (act_q < CW'(TABLE_ENTRIES));
		sts.shift_done = (idx_q <= {1'b0, pick_q} + CW'(1));
		sts.div_done   = (dcnt_q == '0);
		sts.avg_zero   = (quo_q == '0);
		sts.used_none  = (used_q == '0);
		sts.init_done  = (idx_q == CW'(TABLE_ENTRIES - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= CW'(INITIAL_BLOCKS);
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				start_q[k] <= (k < INITIAL_BLOCKS) ? UW'(k * PART) : UW'(MEMORY_UNITS);
				size_q[k]  <= (k < INITIAL_BLOCKS) ? UW'(PART) : '0;
			end
			free_q <= '1;
			idx_q  <= '0;
			st_q   <= '0;
			bi_q   <= '0;
			frag_mode_q <= 1'b0;
			out_st_q    <= '0;
			out_idx_q   <= '0;
			out_frag_q  <= '0;
		end else begin
			if (cmd.clr_idx) idx_q <= '0;
			if (cmd.inc_idx) idx_q <= idx_q + CW'(1);
			if (cmd.load) begin
				st_q <= ST_OK;
				bi_q <= '0;
				frag_mode_q <= (mode == MODE_FRAG);
			end
			if (cmd.set_status) st_q <= cmd.status;
			if (cmd.init_step) begin
				start_q[ix] <= (idx_q < CW'(INITIAL_BLOCKS)) ? UW'(ix) * UW'(PART)
				               : UW'(MEMORY_UNITS);
				size_q[ix]  <= (idx_q < CW'(INITIAL_BLOCKS)) ? UW'(PART) : '0;
				free_q[ix]  <= 1'b1;
			end
			if (cmd.init_end) act_q <= CW'(INITIAL_BLOCKS);
			if (cmd.take) begin
				free_q[pick_q]  <= 1'b0;
				owner_q[pick_q] <= own_q;
				bi_q <= INDEX_W'(pick_q);
			end
			if (cmd.shift_set) idx_q <= act_q;
			if (cmd.shift_step) begin
				start_q[ix] <= start_q[ixm1];
				size_q[ix]  <= size_q[ixm1];
				free_q[ix]  <= free_q[ixm1];
				owner_q[ix] <= owner_q[ixm1];
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.split) begin
				size_q[pick_q]          <= want_q;
				start_q[pick_q + IW'(1)] <= pstart_q + want_q;
				size_q[pick_q + IW'(1)]  <= psize_q - want_q;
				free_q[pick_q + IW'(1)]  <= 1'b1;
				act_q <= act_q + CW'(1);
			end
			if (cmd.free_step && !free_q[ix] && owner_q[ix] == own_q)
				free_q[ix] <= 1'b1;
			// hold the finished result while the next request is worked on
			if (cmd.present) begin
				out_st_q   <= st_q;
				out_idx_q  <= bi_q;
				out_frag_q <= frag_mode_q ? FRAG_W'(hole_q) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			own_q   <= owner_id;
			want_q  <= UW'(req_units);
			zero_q  <= (req_units == '0);
			found_q <= 1'b0;
			sum_q   <= '0;
			used_q  <= '0;
			hole_q  <= '0;
			quo_q   <= '0;
		end
		if (cmd.search && cur_fit && (!found_q || better)) begin
			found_q  <= 1'b1;
			pick_q   <= ix;
			psize_q  <= size_q[ix];
			pstart_q <= start_q[ix];
		end
		if (cmd.sum_step && !free_q[ix]) begin
			sum_q  <= sum_q + SW'(size_q[ix]);
			used_q <= used_q + CW'(1);
		end
		// restoring divide sum / used, one quotient bit per cycle
		if (cmd.div_start) begin
			rem_q  <= '0;
			quo_q  <= sum_q;
			dcnt_q <= DW'(SW);
		end
		if (cmd.div_step) begin
			if (rem_sh >= SW'(used_q)) begin
				rem_q <= rem_sh - SW'(used_q);
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - DW'(1);
		end
		if (cmd.hole_step && free_q[ix] && SW'(size_q[ix]) < quo_q)
			hole_q <= hole_q + size_q[ix];
	end

	assign status     = out_st_q;
	assign slot_index = out_idx_q;
	assign hole_total = out_frag_q;

`ifndef NO_ASSERTIONS
	a_act_bound: assert property (@(posedge clk) disable iff (!arst_n)
		act_q <= CW'(TABLE_ENTRIES)) else $error("active count overflow");
	a_split_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.split |=> act_q == $past(act_q) + CW'(1)) else $error("split count");
	a_take_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> !free_q[$past(pick_q)]) else $error("take failed");
`endif
endmodule

// File: src/variable_partition_allocator_top.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator_top: first/best/worst fit block allocator
// Top level joining the request sequencer and the block table datapath.
// ----------------------------------------------------------------------------
// One request transaction yields one result transaction. The table is walked
// one entry per cycle by a single scan counter. A reinit rewrites every entry;
// an allocate scans the active entries, takes the picked block, and on a split
// shifts the later entries up and writes the split before it presents the
// result; a free sweeps the active entries; a fragmentation query sums the
// used sizes, runs the serial divider of width SW that computes the average
// used size (one quotient bit per cycle), then sums the small free holes.
// The result sits in an output register, so the next request is taken while
// it waits; that request's own result then holds the sequencer until the
// output register has been read.
module variable_partition_allocator_top #(
	parameter int TABLE_ENTRIES = vpa_pkg::TABLE_ENTRIES_DEF,
	parameter int MEMORY_UNITS  = vpa_pkg::MEMORY_UNITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // mode[2:0], owner_id[10:3], req_units[21:11], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status[1:0], slot_index[6:2], hole_total[17:7], zeros
);
	import vpa_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  slot_index;
	logic [FRAG_W-1:0]   hole_total;

	// sequence the request
	vpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.mode(mode_t'(s_tdata[2:0])),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd(cmd), .sts(sts)
	);

	// hold the table and compute
	vpa_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .MEMORY_UNITS(MEMORY_UNITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.mode(mode_t'(s_tdata[2:0])),
		.owner_id(s_tdata[10:3]),
		.req_units(s_tdata[21:11]),
		.cmd(cmd), .sts(sts),
		.status(status), .slot_index(slot_index),
		.hole_total(hole_total)
	);

	assign m_tdata = {6'd0, hole_total, slot_index, status};
endmodule

// File: tb/variable_partition_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator_top_tb: self-checking bench of the allocator
// Drives request transactions into the stream slave, predicts every result
// with a behavioral copy of the block table, and compares each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module variable_partition_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vpa_pkg::*;

	localparam int ENTRIES   = 32;
	localparam int UNITS     = 1024;
	localparam int WATCHDOG  = 20000;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	// first member sits in the highest bits
	typedef struct packed {
		logic [10:0] frag;
		logic [4:0]  index;
		logic [1:0]  status;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	// behavioral copy of the block table
	int unsigned tbl_start [ENTRIES];
	int unsigned tbl_size  [ENTRIES];
	bit          tbl_free  [ENTRIES];
	logic [7:0]  tbl_owner [ENTRIES];
	int unsigned tbl_count;

	alloc_result_t pending_results[$];
	int            error_count;
	int            idle_cycles;
	bit            rx_stall_heavy;

	variable_partition_allocator_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void table_reset();
		for (int k = 0; k < ENTRIES; k++) begin
			tbl_start[k] = (k < INITIAL_BLOCKS) ? k * (UNITS / INITIAL_BLOCKS) : UNITS;
			tbl_size[k]  = (k < INITIAL_BLOCKS) ? UNITS / INITIAL_BLOCKS : 0;
			tbl_free[k]  = 1'b1;
			tbl_owner[k] = '0;
		end
		tbl_count = INITIAL_BLOCKS;
	endfunction

	// Compute the result of one request and update the table copy.
	function automatic alloc_result_t apply_request(logic [2:0] mode, logic [7:0] owner,
			logic [10:0] want);
		alloc_result_t r;
		bit          found;
		int unsigned pick, used, sum, avg, total, st, sz;
		r = '0;
		case (mode)
			MODE_REINIT: table_reset();
			MODE_FIRST, MODE_BEST, MODE_WORST: begin
				if (want == 0) begin
					r.status = ST_BADSIZE;
				end else begin
					found = 0;
					pick = 0;
					for (int k = 0; k < tbl_count; k++) begin
						if (!tbl_free[k] || tbl_size[k] < want) continue;
						if (!found) begin
							found = 1;
							pick = k;
							if (mode == MODE_FIRST) break;
						end else if (mode == MODE_BEST && tbl_size[k] < tbl_size[pick]) begin
							pick = k;
						end else if (mode == MODE_WORST && tbl_size[k] > tbl_size[pick]) begin
							pick = k;
						end
					end
					if (!found) begin
						r.status = ST_NOFIT;
					end else begin
						r.index = pick[4:0];
						st = tbl_start[pick];
						sz = tbl_size[pick];
						tbl_free[pick]  = 0;
						tbl_owner[pick] = owner;
						if (sz != want && tbl_count < ENTRIES) begin
							for (int k = tbl_count; k > pick + 1; k--) begin
								tbl_start[k] = tbl_start[k-1];
								tbl_size[k]  = tbl_size[k-1];
								tbl_free[k]  = tbl_free[k-1];
								tbl_owner[k] = tbl_owner[k-1];
							end
							tbl_count++;
							tbl_size[pick]    = want;
							tbl_start[pick+1] = st + want;
							tbl_size[pick+1]  = sz - want;
							tbl_free[pick+1]  = 1;
							tbl_owner[pick+1] = '0;
						end
					end
				end
			end
			MODE_FREE: begin
				for (int k = 0; k < tbl_count; k++)
					if (!tbl_free[k] && tbl_owner[k] == owner) begin
						tbl_free[k]  = 1;
						tbl_owner[k] = '0;
					end
			end
			MODE_FRAG: begin
				used = 0;
				sum = 0;
				total = 0;
				for (int k = 0; k < tbl_count; k++)
					if (!tbl_free[k]) begin
						sum += tbl_size[k];
						used++;
					end
				if (used != 0) begin
					avg = sum / used;
					if (avg != 0)
						for (int k = 0; k < tbl_count; k++)
							if (tbl_free[k] && tbl_size[k] < avg) total += tbl_size[k];
				end
				r.frag = total[10:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// Send one request transaction; predict its result once it is accepted.
	// Valid stays up after acceptance until the next request or a drain.
	task automatic send_request(logic [2:0] mode, logic [7:0] owner, logic [10:0] want,
			bit with_gaps = 1);
		int g;
		g = with_gaps ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, want, owner, mode};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_request(mode, owner, want));
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	// receiver: random stalls, sometimes long, sometimes none at all
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_stall_heavy) m_tready <= ($urandom_range(0, 99) < 35);
			else m_tready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
		end
	end

	// result checker
	always @(posedge clk) begin
		alloc_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[17:0];
			if (pending_results.size() == 0) begin
				report_mismatch("results outstanding", 0, 1);
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status) report_mismatch("status", got.status, want.status);
				if (got.index != want.index) report_mismatch("slot_index", got.index, want.index);
				if (got.frag != want.frag) report_mismatch("hole_total", got.frag, want.frag);
			end
		end
	end

	// watchdog: count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Extremes of every field, every mode, and the named special cases.
	task automatic test_directed();
		send_request(MODE_FRAG, 8'd0, 11'd0);             // no used blocks
		send_request(MODE_FIRST, 8'd1, 11'd0);            // zero size
		send_request(MODE_BEST, 8'd255, 11'd1024);        // no fit
		send_request(MODE_FIRST, 8'd255, 11'd128);        // exact fit
		send_request(MODE_BEST, 8'd2, 11'd1);             // ties, split
		send_request(MODE_WORST, 8'd3, 11'd100);
		send_request(MODE_WORST, 8'd3, 11'd0);
		send_request(MODE_SPARE6, 8'hAA, 11'h555);        // unused modes
		send_request(MODE_SPARE7, 8'h55, 11'h7FF);
		send_request(MODE_FRAG, 8'd0, 11'd0);
		send_request(MODE_FREE, 8'd3, 11'd0);
		send_request(MODE_FRAG, 8'hFF, 11'h7FF);
		send_request(MODE_FREE, 8'd255, 11'h2AA);
		send_request(MODE_REINIT, 8'hFF, 11'h7FF);
		// fill the table with one-unit splits until it is full
		for (int k = 0; k < 26; k++) send_request(MODE_FIRST, 8'd9, 11'd1, 0);
		send_request(MODE_WORST, 8'd10, 11'd5);           // table full: whole block
		send_request(MODE_FRAG, 8'd0, 11'd0);
		send_request(MODE_REINIT, 8'd0, 11'd0);
	endtask

	// Mostly allocate/free sequences with random content, some noise.
	task automatic test_random(int count);
		logic [2:0]  mode;
		logic [10:0] want;
		int p;
		for (int n = 0; n < count; n++) begin
			p = $urandom_range(0, 99);
			if (p < 2) mode = MODE_REINIT;
			else if (p < 62) mode = 3'($urandom_range(1, 3));
			else if (p < 80) mode = MODE_FREE;
			else if (p < 96) mode = MODE_FRAG;
			else mode = 3'($urandom_range(6, 7));
			p = $urandom_range(0, 99);
			if (p < 60) want = 11'($urandom_range(1, 64));
			else if (p < 90) want = 11'($urandom_range(1, 1024));
			else if (p < 95) want = 11'd0;
			else want = 11'($urandom_range(0, 2047));
			send_request(mode, 8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
				: $urandom_range(0, 5)), want);
			if (n == count / 2) begin
				// hold off the sender until every result is back
				drain_results();
				rx_stall_heavy = 1;
			end
		end
		rx_stall_heavy = 0;
	endtask

	initial begin
		error_count    = 0;
		idle_cycles    = 0;
		rx_stall_heavy = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		table_reset();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1700);
		drain_results();
		if (error_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
